// ===== sv/sba_pkg.sv =====
// Shared types and constants for the slab bitmap allocator.
package sba_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned PAGE_NUM_W = 20;
    localparam int unsigned SLOT_W     = 7;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOTHING    = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NO_PAGE    = 3'd3,
        ST_MISALIGNED = 3'd4,
        ST_DOUBLE     = 3'd5,
        ST_NOT_FOUND  = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SCAN,
        S_A_WR,
        S_A_NEW,
        S_F_RD,
        S_F_CHK,
        S_F_WR,
        S_DONE
    } t_state;

endpackage

// ===== sv/slab_bitmap_allocator.sv =====
// Slab allocator top level: sequencer, page tables and slot bitmap memory.
// A zero, oversize or zero-address item goes straight to the done state. An alloc reads
// each page entry of its class, scans the slots of a page with free slots and writes the
// first free one, or else adds the spare page; a free reads page entries class by class
// until a base matches. One item in flight; busy drops in the o_done cycle. i_rst_n,
// synchronous active low, clears the state, the done flag and the per-class page counts;
// page entries are rewritten when a page is added; the memories need no clearing pass.
module slab_bitmap_allocator #(
    parameter int unsigned CLASS_COUNT     = 8,
    parameter int unsigned PAGES_PER_CLASS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_free_address,
    input  logic [31:0] i_spare_page,
    output logic        o_done,
    output logic [31:0] o_block_address,
    output logic [2:0]  o_status,
    output logic        o_page_taken
);
    localparam int unsigned PW    = (PAGES_PER_CLASS > 1) ? $clog2(PAGES_PER_CLASS) : 1;
    localparam int unsigned CW    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int unsigned TOTAL = CLASS_COUNT * PAGES_PER_CLASS;
    localparam int unsigned IW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned NW    = $clog2(PAGES_PER_CLASS + 1);

    sba_pkg::t_state r_state, n_state;

    logic [NW-1:0]  r_cnt [CLASS_COUNT];
    logic [sba_pkg::PAGE_NUM_W-1:0] m_base [TOTAL];
    logic [7:0]     m_free [TOTAL];
    logic [127:0]   m_bm   [TOTAL];

    logic [31:0] r_addr, r_spare;
    logic [CW-1:0] r_cls;
    logic [PW:0]   r_pg;
    logic [sba_pkg::SLOT_W:0] r_slot;
    logic [sba_pkg::PAGE_NUM_W-1:0] r_base_q;
    logic [7:0]   r_free_q;
    logic [127:0] r_bm_q;
    logic [31:0]  r_res_addr;
    logic [2:0]   r_res_st;
    logic         r_res_pt;
    logic         r_done;

    logic [IW-1:0] w_idx;
    logic [8:0]    w_nslots;
    logic [3:0]    w_cls_full;
    logic [11:0]   w_off;
    logic [11:0]   w_aoff;
    logic [sba_pkg::SLOT_W-1:0] w_fslot;
    logic          w_fmis;
    logic [CW-1:0] w_acls;
    logic          w_abig;
    logic [NW-1:0] w_cnt;
    logic          w_pg_end;
    logic          w_cls_at_max;
    logic          w_last_cls;
    logic          w_base_hit;
    logic          w_slot_end;
    logic          w_slot_free;

    assign w_idx    = IW'(r_cls * PAGES_PER_CLASS + r_pg[PW-1:0]);
    assign w_cls_full = 4'(r_cls);
    assign w_nslots = 9'(9'd128 >> w_cls_full);
    assign w_off    = r_addr[11:0];
    assign w_aoff   = 12'({5'd0, r_slot[sba_pkg::SLOT_W-1:0]} << (w_cls_full + 4'd5));
    assign w_fslot  = sba_pkg::SLOT_W'(w_off >> (w_cls_full + 4'd5));
    assign w_fmis   = ((w_off & 12'((12'd32 << w_cls_full) - 12'd1)) != 12'd0);
    assign w_cnt        = r_cnt[r_cls];
    assign w_pg_end     = (r_pg >= (PW+1)'(w_cnt));
    assign w_cls_at_max = (w_cnt >= NW'(PAGES_PER_CLASS));
    assign w_last_cls   = (r_cls == CW'(CLASS_COUNT - 1));
    assign w_base_hit   = (r_base_q == r_addr[31:12]);
    assign w_slot_end   = ({1'b0, r_slot} >= w_nslots);
    assign w_slot_free  = !r_bm_q[r_slot[sba_pkg::SLOT_W-1:0]];

    // Smallest class whose object size covers the request.
    always_comb begin
        w_acls = '0;
        w_abig = 1'b1;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (i_request_size <= (32'd32 << c)) begin
                w_acls = CW'(c);
                w_abig = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sba_pkg::S_IDLE: begin
                if (start) begin
                    if (i_mode)
                        n_state = (i_free_address == 32'd0) ? sba_pkg::S_DONE
                                                            : sba_pkg::S_F_RD;
                    else
                        n_state = (i_request_size == 32'd0 || w_abig) ? sba_pkg::S_DONE
                                                                      : sba_pkg::S_A_RD;
                end
            end
            sba_pkg::S_A_RD: begin
                if (w_pg_end)
                    n_state = (w_cls_at_max || r_spare == 32'd0) ? sba_pkg::S_DONE
                                                                 : sba_pkg::S_A_NEW;
                else
                    n_state = sba_pkg::S_A_CHK;
            end
            sba_pkg::S_A_CHK:
                n_state = (r_free_q == 8'd0) ? sba_pkg::S_A_RD : sba_pkg::S_A_SCAN;
            sba_pkg::S_A_SCAN: begin
                if (w_slot_end)       n_state = sba_pkg::S_A_RD;
                else if (w_slot_free) n_state = sba_pkg::S_A_WR;
            end
            sba_pkg::S_A_WR:   n_state = sba_pkg::S_DONE;
            sba_pkg::S_A_NEW:  n_state = sba_pkg::S_DONE;
            sba_pkg::S_F_RD: begin
                if (w_pg_end) begin
                    if (w_last_cls) n_state = sba_pkg::S_DONE;
                end else begin
                    n_state = sba_pkg::S_F_CHK;
                end
            end
            sba_pkg::S_F_CHK: begin
                if (w_base_hit)
                    n_state = (w_fmis || !r_bm_q[w_fslot]) ? sba_pkg::S_DONE
                                                            : sba_pkg::S_F_WR;
                else
                    n_state = sba_pkg::S_F_RD;
            end
            sba_pkg::S_F_WR:   n_state = sba_pkg::S_DONE;
            sba_pkg::S_DONE:   n_state = sba_pkg::S_IDLE;
            default:           n_state = sba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy            = (r_state != sba_pkg::S_IDLE);
        o_done          = r_done;
        o_block_address = r_res_addr;
        o_status        = r_res_st;
        o_page_taken    = r_res_pt;
    end

    always_ff @(posedge i_clk) begin
        r_base_q <= m_base[w_idx];
        r_free_q <= m_free[w_idx];
        r_bm_q   <= m_bm[w_idx];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sba_pkg::S_A_WR: begin
                m_bm[w_idx]   <= r_bm_q | (128'd1 << r_slot[sba_pkg::SLOT_W-1:0]);
                m_free[w_idx] <= r_free_q - 8'd1;
            end
            sba_pkg::S_A_NEW: begin
                // Fresh page: slot 0 taken at once.
                m_base[w_idx] <= r_spare[31:12];
                m_free[w_idx] <= 8'(w_nslots - 9'd1);
                m_bm[w_idx]   <= 128'd1;
            end
            sba_pkg::S_F_WR: begin
                m_bm[w_idx]   <= r_bm_q & ~(128'd1 << w_fslot);
                m_free[w_idx] <= r_free_q + 8'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sba_pkg::S_IDLE;
            r_done  <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++) r_cnt[c] <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == sba_pkg::S_DONE);
            if (r_state == sba_pkg::S_A_NEW) r_cnt[r_cls] <= r_cnt[r_cls] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sba_pkg::S_IDLE: begin
                if (start) begin
                    r_addr     <= i_free_address;
                    r_spare    <= i_spare_page;
                    r_res_addr <= '0;
                    r_res_pt   <= 1'b0;
                    r_cls      <= i_mode ? '0 : w_acls;
                    r_pg       <= '0;
                    r_slot     <= '0;
                    if (!i_mode && i_request_size != 32'd0 && w_abig)
                        r_res_st <= sba_pkg::ST_TOO_LARGE;
                    else
                        r_res_st <= sba_pkg::ST_NOTHING;
                end
            end
            sba_pkg::S_A_RD: begin
                // No page with a free slot and no way to grow the class.
                if (w_pg_end && (w_cls_at_max || r_spare == 32'd0))
                    r_res_st <= sba_pkg::ST_NO_PAGE;
            end
            sba_pkg::S_A_CHK: begin
                // Skip a page with no free slots.
                if (r_free_q == 8'd0) r_pg   <= r_pg + 1'b1;
                else                  r_slot <= '0;
            end
            sba_pkg::S_A_SCAN: begin
                if (w_slot_end)        r_pg   <= r_pg + 1'b1;
                else if (!w_slot_free) r_slot <= r_slot + 1'b1;
            end
            sba_pkg::S_A_WR: begin
                r_res_addr <= {r_base_q, w_aoff};
                r_res_st   <= sba_pkg::ST_OK;
            end
            sba_pkg::S_A_NEW: begin
                r_res_addr <= {r_spare[31:12], 12'd0};
                r_res_pt   <= 1'b1;
                r_res_st   <= sba_pkg::ST_OK;
            end
            sba_pkg::S_F_RD: begin
                // Advance past exhausted classes.
                if (w_pg_end) begin
                    if (w_last_cls) begin
                        r_res_st <= sba_pkg::ST_NOT_FOUND;
                    end else begin
                        r_cls <= r_cls + 1'b1;
                        r_pg  <= '0;
                    end
                end
            end
            sba_pkg::S_F_CHK: begin
                if (w_base_hit) begin
                    if (w_fmis)                r_res_st <= sba_pkg::ST_MISALIGNED;
                    else if (!r_bm_q[w_fslot]) r_res_st <= sba_pkg::ST_DOUBLE;
                end else begin
                    r_pg <= r_pg + 1'b1;
                end
            end
            sba_pkg::S_F_WR: r_res_st <= sba_pkg::ST_OK;
            default: ;
        endcase
    end

endmodule

// ===== sv/sba_checker.sv =====
// Port-level checks for the slab bitmap allocator, bound to the top level.
module sba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic        o_page_taken,
    input logic [31:0] o_block_address
);
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= sba_pkg::ST_NOT_FOUND)) else $error("bad status");
    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_page_taken) |-> (o_status == sba_pkg::ST_OK))
        else $error("page taken w/o ok");
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != sba_pkg::ST_OK) |-> (o_block_address == 32'd0))
        else $error("addr");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy");
endmodule

bind slab_bitmap_allocator sba_checker u_sba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_status(o_status), .o_page_taken(o_page_taken), .o_block_address(o_block_address)
);
